// ===== rtl/core/hcpp_pkg.sv =====
// shared constants, beat types and register indexes of the hard-core point placer
package hcpp_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int COORD_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int SQ_W       = 50;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int ENTRY_W    = 3 * COORD_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SQ_W;

  localparam logic [SQ_W-1:0] SQ_ALL = {SQ_W{1'b1}};

  // register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_SPAN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_SPAN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SQ_DIST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 3'd5;

  // item function codes
  localparam logic FUNC_PLACE = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic              func;
    logic [FRAC_W-1:0] rand_x;
    logic [FRAC_W-1:0] rand_y;
    logic [FRAC_W-1:0] rand_z;
  } cand_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      accepted;
    logic [CNT_W-1:0]          point_index;
    logic [SQ_W-1:0]           nearest_sq;
    logic                      done_res;
  } res_t;

endpackage

// ===== rtl/core/hcpp_ram.sv =====
// generic single-write, single-read ram with registered read data
module hcpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/hard_core_point_placer.sv =====
// top level of the hard-core point placer: sequencer, shared multiplier and point store
//
// usage
//   candidate channel (cand_valid / cand_stall / cand): each beat either offers
//   a candidate (func place) with three 16-bit uniform fractions, or clears the
//   store (func clear). result channel (res_valid / res_stall / res): exactly
//   one result beat per candidate beat, in order.
//   config port (wr_en / wr_index / wr_data): write only while the block is idle.
// sequencing
//   clear and done beats: the result passes the finish state into the output register.
//   placed candidate: the three coordinates are formed, then every stored point
//   is scanned; the next beat can be taken once the result is handed to the output.
//   the scan takes one stored point at a time: three squarings on the single
//   24x24 multiplier and one accumulate/compare step; the store has one read port.
//   the block takes one beat at a time; cand_stall is high while it works.
// reset
//   synchronous, active high: store count goes to zero, registers to their
//   defaults (target count 1), no result pending. store contents are not cleared.
// stalls
//   a finished result waits in the output register; a new candidate can be
//   taken meanwhile, and its result waits in the sequencer until res_stall drops.
module hard_core_point_placer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cand_valid,
  output logic                             cand_stall,
  input  hcpp_pkg::cand_t                  cand,
  output logic                             res_valid,
  input  logic                             res_stall,
  output hcpp_pkg::res_t                   res,
  input  logic                             wr_en,
  input  logic [hcpp_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [hcpp_pkg::CFG_DATA_W-1:0]  wr_data
);

  import hcpp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE_MUL,
    ST_PLACE_ADD,
    ST_SCAN_RD,
    ST_SCAN_AX,
    ST_SCAN_ACC,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  // configuration registers
  logic signed [COORD_W-1:0] cross_low;
  logic [COORD_W-1:0]        cross_span;
  logic signed [COORD_W-1:0] length_low;
  logic [COORD_W-1:0]        length_span;
  logic [SQ_W-1:0]           min_sq_dist;
  logic [CNT_W-1:0]          target_count;

  // sequencer state and datapath registers
  state_t                    state;
  logic [1:0]                ax;
  cand_t                     item;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic [PROD_W-1:0]         prod;
  logic [SQ_W-1:0]           sum;
  logic [SQ_W-1:0]           near;
  logic [ADDR_W-1:0]         idx;
  logic [CNT_W-1:0]          count;
  res_t                      pend;

  // combinational datapath
  logic [CNT_W-1:0]          eff_tgt;
  logic [COORD_W-1:0]        mul_a;
  logic [COORD_W-1:0]        mul_b;
  logic [FRAC_W-1:0]         frac_sel;
  logic [COORD_W-1:0]        span_sel;
  logic signed [COORD_W-1:0] low_sel;
  logic signed [COORD_W-1:0] pos_sel;
  logic signed [COORD_W-1:0] ent_sel;
  logic signed [COORD_W:0]   diff;
  logic [COORD_W:0]          mag;
  logic signed [COORD_W+1:0] csum;
  logic signed [COORD_W-1:0] coord;
  logic [SQ_W-1:0]           total;
  logic                      acc_now;
  logic [CNT_W-1:0]          cnt_after;
  logic [CNT_W-1:0]          idx_next;

  // store port signals
  logic                      st_wr_en;
  logic                      st_rd_en;
  logic [ADDR_W-1:0]         st_rd_addr;
  logic [ENTRY_W-1:0]        st_rd_data;

  // target above the store depth saturates to the depth
  assign eff_tgt = (target_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : target_count;

  // busy for the whole life of an item
  assign cand_stall = (state != ST_IDLE);

  // per-axis selection: y uses the length registers, x and z the cross ones
  always_comb begin
    case (ax)
      2'd0: begin
        frac_sel = item.rand_x;
        pos_sel  = pos_x;
        ent_sel  = st_rd_data[3*COORD_W-1:2*COORD_W];
      end
      2'd1: begin
        frac_sel = item.rand_y;
        pos_sel  = pos_y;
        ent_sel  = st_rd_data[2*COORD_W-1:COORD_W];
      end
      default: begin
        frac_sel = item.rand_z;
        pos_sel  = pos_z;
        ent_sel  = st_rd_data[COORD_W-1:0];
      end
    endcase
    span_sel = (ax == 2'd1) ? length_span : cross_span;
    low_sel  = (ax == 2'd1) ? length_low : cross_low;
  end

  // axis difference magnitude, never above 2^24 - 1
  assign diff = {pos_sel[COORD_W-1], pos_sel} - {ent_sel[COORD_W-1], ent_sel};
  assign mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;

  // shared multiplier operands: span times fraction while placing, squares while scanning
  always_comb begin
    if (state == ST_SCAN_AX) begin
      mul_a = mag[COORD_W-1:0];
      mul_b = mag[COORD_W-1:0];
    end else begin
      mul_a = span_sel;
      mul_b = {{(COORD_W-FRAC_W){1'b0}}, frac_sel};
    end
  end

  // low plus scaled offset, saturated to the signed coordinate range
  assign csum = {{2{low_sel[COORD_W-1]}}, low_sel}
              + {2'b00, prod[FRAC_W+COORD_W-1:FRAC_W]};
  always_comb begin
    if (csum[COORD_W+1:COORD_W-1] == 3'b000 || csum[COORD_W+1:COORD_W-1] == 3'b111) begin
      coord = csum[COORD_W-1:0];
    end else if (csum[COORD_W+1]) begin
      coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      coord = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  // three squares of at most 48 bits each fit the 50-bit sum
  assign total     = sum + {{(SQ_W-PROD_W){1'b0}}, prod};
  assign acc_now   = (count == '0) || (near >= min_sq_dist);
  assign cnt_after = acc_now ? count + 1'b1 : count;
  assign idx_next  = {1'b0, idx} + 1'b1;

  // store access: first point read in its own state, later ones prefetched
  assign st_wr_en   = (state == ST_DECIDE) && acc_now;
  assign st_rd_en   = (state == ST_SCAN_RD) || (state == ST_SCAN_AX && ax == 2'd2);
  assign st_rd_addr = (state == ST_SCAN_RD) ? idx : idx_next[ADDR_W-1:0];

  hcpp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data ({pos_x, pos_y, pos_z}),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cross_low    <= '0;
      cross_span   <= '0;
      length_low   <= '0;
      length_span  <= '0;
      min_sq_dist  <= '0;
      target_count <= CNT_W'(1);
    end else if (wr_en) begin
      case (wr_index)
        REG_CROSS_LOW:    cross_low    <= wr_data[COORD_W-1:0];
        REG_CROSS_SPAN:   cross_span   <= wr_data[COORD_W-1:0];
        REG_LENGTH_LOW:   length_low   <= wr_data[COORD_W-1:0];
        REG_LENGTH_SPAN:  length_span  <= wr_data[COORD_W-1:0];
        REG_MIN_SQ_DIST:  min_sq_dist  <= wr_data[SQ_W-1:0];
        REG_TARGET_COUNT: target_count <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      count     <= '0;
      ax        <= '0;
    end else begin
      prod <= mul_a * mul_b;

      // output beat taken; in the finish state the handoff below decides
      if (res_valid && !res_stall && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cand_valid) begin
            item <= cand;
            if (cand.func == FUNC_CLEAR) begin
              count            <= '0;
              pend.pos_x       <= '0;
              pend.pos_y       <= '0;
              pend.pos_z       <= '0;
              pend.accepted    <= 1'b0;
              pend.point_index <= '0;
              pend.nearest_sq  <= SQ_ALL;
              pend.done_res    <= (eff_tgt == '0);
              state            <= ST_FINISH;
            end else if (count >= eff_tgt) begin
              // target reached: candidate ignored
              pend.pos_x       <= '0;
              pend.pos_y       <= '0;
              pend.pos_z       <= '0;
              pend.accepted    <= 1'b0;
              pend.point_index <= count;
              pend.nearest_sq  <= '0;
              pend.done_res    <= 1'b1;
              state            <= ST_FINISH;
            end else begin
              ax    <= 2'd0;
              state <= ST_PLACE_MUL;
            end
          end
        end

        ST_PLACE_MUL: begin
          state <= ST_PLACE_ADD;
        end

        ST_PLACE_ADD: begin
          case (ax)
            2'd0:    pos_x <= coord;
            2'd1:    pos_y <= coord;
            default: pos_z <= coord;
          endcase
          if (ax == 2'd2) begin
            near  <= SQ_ALL;
            idx   <= '0;
            state <= (count == '0) ? ST_DECIDE : ST_SCAN_RD;
          end else begin
            ax    <= ax + 2'd1;
            state <= ST_PLACE_MUL;
          end
        end

        ST_SCAN_RD: begin
          ax    <= 2'd0;
          sum   <= '0;
          state <= ST_SCAN_AX;
        end

        ST_SCAN_AX: begin
          // product of the previous axis lands here
          if (ax != 2'd0) begin
            sum <= total;
          end
          if (ax == 2'd2) begin
            state <= ST_SCAN_ACC;
          end else begin
            ax <= ax + 2'd1;
          end
        end

        ST_SCAN_ACC: begin
          if (total < near) begin
            near <= total;
          end
          ax  <= 2'd0;
          sum <= '0;
          if (idx_next == count) begin
            state <= ST_DECIDE;
          end else begin
            idx   <= idx_next[ADDR_W-1:0];
            state <= ST_SCAN_AX;
          end
        end

        ST_DECIDE: begin
          count            <= cnt_after;
          pend.pos_x       <= pos_x;
          pend.pos_y       <= pos_y;
          pend.pos_z       <= pos_z;
          pend.accepted    <= acc_now;
          pend.point_index <= cnt_after;
          pend.nearest_sq  <= near;
          pend.done_res    <= (cnt_after >= eff_tgt);
          state            <= ST_FINISH;
        end

        ST_FINISH: begin
          // wait for the output register to free up
          if (!res_valid || !res_stall) begin
            res       <= pend;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
